### design/rwg_pkg.sv
// Shared types, register codes and waveform table builders for the waveform generator.
package rwg_pkg;

    typedef enum logic [2:0] {
        MODE_SINE     = 3'd0,
        MODE_SQUARE   = 3'd1,
        MODE_TRIANGLE = 3'd2,
        MODE_COUNTER  = 3'd3,
        MODE_SAWTOOTH = 3'd4,
        MODE_PULSE    = 3'd5,
        MODE_DAMPED   = 3'd6
    } mode_t;

    localparam logic [2:0] REG_MINIMUM = 3'd0;
    localparam logic [2:0] REG_MAXIMUM = 3'd1;
    localparam logic [2:0] REG_PERIOD  = 3'd2;
    localparam logic [2:0] REG_STEP    = 3'd3;
    localparam logic [2:0] REG_COUNT   = 3'd4;

    localparam int PHASE_BITS    = 16;
    localparam int MAX_REGISTERS = 65536;
    localparam int DIV_STEPS     = 4;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint unsigned TWO_PI_Q30  = PI_Q30 * 2;

    // Magnitude of sin(angle) in Q2.30 for an angle below four pi, with its sign.
    function automatic longint unsigned sin_mag(input longint unsigned angle,
                                                output logic neg);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        a = angle;
        neg = 1'b0;
        if (a >= TWO_PI_Q30)
            a = a - TWO_PI_Q30;
        if (a >= PI_Q30)
        begin
            neg = 1'b1;
            a = a - PI_Q30;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        x2 = (a * a) >> 30;
        term = a;
        sum = a;
        term = ((term * x2) >> 30) / 6;   sum = sum - term;
        term = ((term * x2) >> 30) / 20;  sum = sum + term;
        term = ((term * x2) >> 30) / 42;  sum = sum - term;
        term = ((term * x2) >> 30) / 72;  sum = sum + term;
        term = ((term * x2) >> 30) / 110; sum = sum - term;
        term = ((term * x2) >> 30) / 156; sum = sum + term;
        term = ((term * x2) >> 30) / 210; sum = sum - term;
        term = ((term * x2) >> 30) / 272; sum = sum + term;
        return (sum > ONE_Q30) ? ONE_Q30 : sum;
    endfunction

    // exp(-y) in Q2.30 for y below four, by a series on y/8 squared three times.
    function automatic longint unsigned exp_neg(input longint unsigned y);
        longint unsigned t;
        longint unsigned term;
        longint unsigned sum;
        t = y >> 3;
        term = ONE_Q30;
        sum = ONE_Q30;
        term = ((term * t) >> 30) / 1;  sum = sum - term;
        term = ((term * t) >> 30) / 2;  sum = sum + term;
        term = ((term * t) >> 30) / 3;  sum = sum - term;
        term = ((term * t) >> 30) / 4;  sum = sum + term;
        term = ((term * t) >> 30) / 5;  sum = sum - term;
        term = ((term * t) >> 30) / 6;  sum = sum + term;
        term = ((term * t) >> 30) / 7;  sum = sum - term;
        term = ((term * t) >> 30) / 8;  sum = sum + term;
        term = ((term * t) >> 30) / 9;  sum = sum - term;
        term = ((term * t) >> 30) / 10; sum = sum + term;
        term = ((term * t) >> 30) / 11; sum = sum - term;
        term = ((term * t) >> 30) / 12; sum = sum + term;
        sum = (sum * sum) >> 30;
        sum = (sum * sum) >> 30;
        sum = (sum * sum) >> 30;
        return sum;
    endfunction

    function automatic logic [16:0] sine_entry(input longint unsigned angle);
        logic neg;
        longint unsigned s;
        longint unsigned v;
        s = sin_mag(angle, neg);
        v = neg ? (ONE_Q30 - s) : (ONE_Q30 + s);
        return 17'((v + (64'd1 << 14)) >> 15);
    endfunction

    function automatic logic [16:0] damped_entry(input longint unsigned angle,
                                                 input longint unsigned earg);
        logic neg;
        longint unsigned c;
        longint unsigned env;
        longint unsigned prod;
        longint unsigned v;
        c = sin_mag(angle + HALF_PI_Q30, neg);
        env = exp_neg(earg);
        prod = (env * c) >> 30;
        if (prod > ONE_Q30)
            prod = ONE_Q30;
        v = neg ? (ONE_Q30 - prod) : (ONE_Q30 + prod);
        return 17'((v + (64'd1 << 14)) >> 15);
    endfunction

endpackage

### design/rwg_divider.sv
// Pipelined restoring divider that resolves up to STEPS quotient bits per stage.
module rwg_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int STEPS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             out_valid,
    output logic [NUM_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder
);

    localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;

    logic [STAGES-1:0] valid_reg;
    logic [DEN_W-1:0]  rem_reg [STAGES];
    logic [NUM_W-1:0]  dq_reg  [STAGES];

    // Users must hold the divisor steady with requests in flight; nothing enforces it.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic             v_in;
        logic [DEN_W-1:0] r_in;
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] dq_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = numer;
        end
        else
        begin : g_rest
            assign v_in = valid_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign q_in = dq_reg[s-1];
        end

        // Dividend bits leave the top of dq while quotient bits enter at the bottom.
        always_comb
        begin
            logic [DEN_W:0] sh;
            rem_next = r_in;
            dq_next  = q_in;
            sh       = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (s * STEPS + j < NUM_W)
                begin
                    sh = {rem_next, dq_next[NUM_W-1]};
                    if (sh >= {1'b0, denom})
                    begin
                        sh      = sh - {1'b0, denom};
                        dq_next = {dq_next[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dq_next = {dq_next[NUM_W-2:0], 1'b0};
                    end
                    rem_next = sh[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            dq_reg[s]  <= dq_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = dq_reg[STAGES-1];
    assign remainder = rem_reg[STAGES-1];

endmodule

### design/rwg_rom.sv
// Constant waveform table with a registered read port.
module rwg_rom
    import rwg_pkg::*;
#(
    parameter int ENTRIES = 1024,
    parameter bit DAMPED  = 1'b0
) (
    input  logic                       clk,
    input  logic [$clog2(ENTRIES)-1:0] addr,
    output logic [16:0]                data
);

    logic [16:0] tab [ENTRIES];
    logic [16:0] data_reg;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_tab
        localparam longint unsigned ANGLE = (TWO_PI_Q30 * 64'(k)) / ENTRIES;
        localparam longint unsigned EARG  = (64'(k) << 32) / ENTRIES;
        assign tab[k] = DAMPED ? damped_entry(ANGLE, EARG) : sine_entry(ANGLE);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule

### design/register_waveform_generator_unit.sv
// Top level of the waveform generator: config registers, dividers, tables and scaling.
// The done strobe follows the capture register, both dividers, then the decode, scaling and output registers.
// Throughput: one request per cycle; busy stays low and results cannot be held off.
// The depth is set by the two chained dividers (tick modulo period, then phase).
// Reset clears the configuration to its defaults and empties every pipeline stage.
module register_waveform_generator_unit
    import rwg_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [31:0] tick,
    input  logic [15:0] index,
    output logic        done,
    output logic [15:0] value,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [16:0] wr_data
);

    localparam int AW       = $clog2(TABLE_ENTRIES);
    localparam int L_MOD    = (32 + DIV_STEPS - 1) / DIV_STEPS;
    localparam int L_PHASE  = (32 + DIV_STEPS - 1) / DIV_STEPS;
    localparam int L_OFF    = (36 + DIV_STEPS - 1) / DIV_STEPS;
    localparam int L_CNT    = (49 + DIV_STEPS - 1) / DIV_STEPS;
    localparam int T_ALIGN  = L_MOD + L_PHASE;
    localparam int OFF_DLY  = T_ALIGN - L_OFF;
    localparam int CNT_DLY  = T_ALIGN - 1 - L_CNT;
    localparam int PT_DLY   = L_PHASE;
    localparam int MODE_DLY = T_ALIGN;
    localparam int TOTAL_LAT = T_ALIGN + 3;

    // Configuration registers and values derived from them.
    logic [15:0] min_reg, max_reg, tpp_reg, step_reg;
    logic [16:0] count_reg;
    logic [15:0] period_reg, pwidth_reg, sspan_reg;
    logic [16:0] span_reg;
    logic [22:0] offden_reg;
    logic        offen_reg, scale_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= 16'd0;
            max_reg   <= 16'd65535;
            tpp_reg   <= 16'd20;
            step_reg  <= 16'd1;
            count_reg <= 17'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MINIMUM: min_reg   <= wr_data[15:0];
                REG_MAXIMUM: max_reg   <= wr_data[15:0];
                REG_PERIOD:  tpp_reg   <= wr_data[15:0];
                REG_STEP:    step_reg  <= wr_data[15:0];
                REG_COUNT:   count_reg <= wr_data;
                default:     ;
            endcase
        end
    end

    logic [15:0] period_c;
    logic [16:0] count_c;
    logic [34:0] tenth_c;

    always_comb
    begin
        period_c = (tpp_reg < 16'd2) ? 16'd2 : tpp_reg;
        count_c  = (count_reg > 17'(MAX_REGISTERS)) ? 17'(MAX_REGISTERS) : count_reg;
        // Exact floor of a 16-bit value divided by ten.
        tenth_c  = 35'(period_c) * 35'd52429;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= 16'd20;
            pwidth_reg   <= 16'd2;
            sspan_reg    <= 16'd65535;
            span_reg     <= 17'd0;
            offden_reg   <= 23'd100;
            offen_reg    <= 1'b0;
            scale_ok_reg <= 1'b1;
        end
        else
        begin
            period_reg   <= period_c;
            pwidth_reg   <= (tenth_c[34:19] == 16'd0) ? 16'd1 : tenth_c[34:19];
            sspan_reg    <= max_reg - min_reg;
            span_reg     <= 17'(max_reg) - 17'(min_reg) + 17'd1;
            offden_reg   <= 23'(count_c) * 23'd100;
            offen_reg    <= count_c > 17'd1;
            scale_ok_reg <= max_reg >= min_reg;
        end
    end

    // Request capture.
    logic        v0_reg;
    logic [2:0]  mode0_reg;
    logic [31:0] tick0_reg;
    logic [15:0] index0_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        mode0_reg  <= mode;
        tick0_reg  <= tick;
        index0_reg <= index;
    end

    // Tick modulo period, then the phase fraction.
    logic        mod_valid;
    logic [31:0] mod_quot;
    logic [15:0] pt;
    logic        ph_valid;
    logic [31:0] ph_quot;
    logic [15:0] ph_rem;

    rwg_divider #(.NUM_W(32), .DEN_W(16), .STEPS(DIV_STEPS)) u_mod_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .numer     (tick0_reg),
        .denom     (period_reg),
        .out_valid (mod_valid),
        .quotient  (mod_quot),
        .remainder (pt)
    );

    rwg_divider #(.NUM_W(32), .DEN_W(16), .STEPS(DIV_STEPS)) u_phase_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mod_valid),
        .numer     ({pt, 16'd0}),
        .denom     (period_reg),
        .out_valid (ph_valid),
        .quotient  (ph_quot),
        .remainder (ph_rem)
    );

    // Per-index sine phase offset.
    logic [19:0] idx12;
    logic        off_valid;
    logic [35:0] off_quot;
    logic [22:0] off_rem;

    assign idx12 = 20'(index0_reg) * 20'd12;

    rwg_divider #(.NUM_W(36), .DEN_W(23), .STEPS(DIV_STEPS)) u_off_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .numer     ({idx12, 16'd0}),
        .denom     (offden_reg),
        .out_valid (off_valid),
        .quotient  (off_quot),
        .remainder (off_rem)
    );

    // Counter mode: (tick + index) * step modulo the span.
    logic        cp_valid_reg;
    logic [48:0] cp_reg;
    logic        cnt_valid;
    logic [48:0] cnt_quot;
    logic [16:0] cnt_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_valid_reg <= 1'b0;
        else
            cp_valid_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        cp_reg <= (49'(tick0_reg) + 49'(index0_reg)) * 49'(step_reg);
    end

    rwg_divider #(.NUM_W(49), .DEN_W(17), .STEPS(DIV_STEPS)) u_cnt_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cp_valid_reg),
        .numer     (cp_reg),
        .denom     (span_reg),
        .out_valid (cnt_valid),
        .quotient  (cnt_quot),
        .remainder (cnt_rem)
    );

    // Alignment delay lines up to the point where the phase is known.
    logic [2:0]  mode_dly_reg [MODE_DLY];
    logic [15:0] pt_dly_reg   [PT_DLY];
    logic [15:0] off_dly_reg  [OFF_DLY];
    logic [16:0] cnt_dly_reg  [CNT_DLY];

    always_ff @(posedge clk)
    begin
        mode_dly_reg[0] <= mode0_reg;
        for (int i = 1; i < MODE_DLY; i++)
            mode_dly_reg[i] <= mode_dly_reg[i-1];
        pt_dly_reg[0] <= pt;
        for (int i = 1; i < PT_DLY; i++)
            pt_dly_reg[i] <= pt_dly_reg[i-1];
        off_dly_reg[0] <= off_quot[15:0];
        for (int i = 1; i < OFF_DLY; i++)
            off_dly_reg[i] <= off_dly_reg[i-1];
        cnt_dly_reg[0] <= cnt_rem;
        for (int i = 1; i < CNT_DLY; i++)
            cnt_dly_reg[i] <= cnt_dly_reg[i-1];
    end

    // Waveform decode with the phase in hand.
    logic [15:0]         phase;
    logic [15:0]         total;
    logic [16:0]         tri_c;
    logic [16:0]         lin_c;
    logic [15:0]         direct_c;
    logic                scale_c;
    logic [15:0]         fold_c;
    logic [PHASE_BITS+AW:0] sine_ax, damp_ax;
    logic [AW-1:0]       sine_addr, damp_addr;
    logic [2:0]          mode_a;

    assign phase  = ph_quot[15:0];
    assign mode_a = mode_dly_reg[MODE_DLY-1];

    always_comb
    begin
        total     = phase + (offen_reg ? off_dly_reg[OFF_DLY-1] : 16'd0);
        sine_ax   = (PHASE_BITS+AW+1)'(total) * (PHASE_BITS+AW+1)'(TABLE_ENTRIES);
        damp_ax   = (PHASE_BITS+AW+1)'(phase) * (PHASE_BITS+AW+1)'(TABLE_ENTRIES);
        sine_addr = sine_ax[PHASE_BITS +: AW];
        damp_addr = damp_ax[PHASE_BITS +: AW];
        fold_c    = 16'(17'h10000 - 17'(phase));
        tri_c     = phase[15] ? {fold_c, 1'b0} : {phase, 1'b0};
        lin_c     = 17'(phase);
        direct_c  = min_reg;
        scale_c   = 1'b0;
        unique case (mode_a)
            MODE_SINE, MODE_SAWTOOTH, MODE_DAMPED:
            begin
                scale_c = scale_ok_reg;
            end
            MODE_TRIANGLE:
            begin
                lin_c   = tri_c;
                scale_c = scale_ok_reg;
            end
            MODE_SQUARE:
            begin
                direct_c = phase[15] ? max_reg : min_reg;
            end
            MODE_PULSE:
            begin
                direct_c = (pt_dly_reg[PT_DLY-1] < pwidth_reg) ? max_reg : min_reg;
            end
            MODE_COUNTER:
            begin
                if (scale_ok_reg)
                    direct_c = min_reg + cnt_dly_reg[CNT_DLY-1][15:0];
            end
            default: ;
        endcase
    end

    logic [16:0] sine_q, damp_q;

    rwg_rom #(.ENTRIES(TABLE_ENTRIES), .DAMPED(1'b0)) u_sine_rom (
        .clk  (clk),
        .addr (sine_addr),
        .data (sine_q)
    );

    rwg_rom #(.ENTRIES(TABLE_ENTRIES), .DAMPED(1'b1)) u_damp_rom (
        .clk  (clk),
        .addr (damp_addr),
        .data (damp_q)
    );

    logic        s1_valid_reg;
    logic [2:0]  s1_mode_reg;
    logic [16:0] s1_lin_reg;
    logic [15:0] s1_direct_reg;
    logic        s1_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= ph_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg   <= mode_a;
        s1_lin_reg    <= lin_c;
        s1_direct_reg <= direct_c;
        s1_scale_reg  <= scale_c;
    end

    // Scale the ratio into the output range.
    logic [16:0] ratio_c;
    logic        s2_valid_reg;
    logic [32:0] s2_prod_reg;
    logic [15:0] s2_direct_reg;
    logic        s2_scale_reg;

    always_comb
    begin
        case (s1_mode_reg)
            MODE_SINE:   ratio_c = sine_q;
            MODE_DAMPED: ratio_c = damp_q;
            default:     ratio_c = s1_lin_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg   <= 33'(sspan_reg) * 33'(ratio_c);
        s2_direct_reg <= s1_direct_reg;
        s2_scale_reg  <= s1_scale_reg;
    end

    logic        done_reg;
    logic [15:0] value_reg;
    logic [32:0] rounded;

    assign rounded = s2_prod_reg + 33'd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= s2_scale_reg ? (min_reg + rounded[31:16]) : s2_direct_reg;
    end

    assign done  = done_reg;
    assign value = value_reg;

    // Every result strobe traces back to a captured request.
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v0_reg, TOTAL_LAT))
        else $error("result strobe without a matching request");

    // Linear ratios never exceed one in Q1.16.
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_lin_reg <= 17'd65536))
        else $error("linear ratio out of range");

    // The side paths reach the alignment point together with the phase.
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        ph_valid |-> $past(off_valid, OFF_DLY) && $past(cnt_valid, CNT_DLY))
        else $error("divider paths out of alignment");

endmodule

### tb/tb_register_waveform_generator_unit.sv
// Self-checking testbench for the register waveform generator: directed table, then random requests.
module tb_register_waveform_generator_unit;
    import rwg_pkg::*;

    localparam int ENTRIES = 1024;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [31:0] tick;
    logic [15:0] index;
    logic        done;
    logic [15:0] value;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [16:0] wr_data;

    register_waveform_generator_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .tick(tick), .index(index),
        .done(done), .value(value),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow configuration kept by the predictor.
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [15:0] cfg_period;
    logic [15:0] cfg_step;
    logic [16:0] cfg_count;

    logic [16:0] sine_table [ENTRIES];
    logic [16:0] damped_table [ENTRIES];

    logic [15:0] pending_values [$];
    int errors;
    int idle_cycles;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] tick;
        logic [15:0] index;
        bit          known;
        logic [15:0] value;
    } vector_t;

    vector_t vectors [$];

    // Independent tables computed with the same Q2.30 series.
    function automatic longint unsigned sine_abs(input longint unsigned angle, output bit neg);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        a = angle;
        neg = 0;
        while (a >= TWO_PI_Q30)
            a -= TWO_PI_Q30;
        if (a >= PI_Q30)
        begin
            neg = 1;
            a -= PI_Q30;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        x2 = (a * a) >> 30;
        term = a;
        sum = a;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        return sum > ONE_Q30 ? ONE_Q30 : sum;
    endfunction

    function automatic longint unsigned decay(input longint unsigned y);
        longint unsigned t;
        longint unsigned term;
        longint unsigned sum;
        t = y >> 3;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * t) >> 30) / n;
            if (n % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        for (int i = 0; i < 3; i++)
            sum = (sum * sum) >> 30;
        return sum;
    endfunction

    task automatic fill_tables();
        bit neg;
        longint unsigned angle;
        longint unsigned s;
        longint unsigned v;
        longint unsigned prod;
        for (int k = 0; k < ENTRIES; k++)
        begin
            angle = (TWO_PI_Q30 * k) / ENTRIES;
            s = sine_abs(angle, neg);
            v = neg ? ONE_Q30 - s : ONE_Q30 + s;
            sine_table[k] = 17'((v + (64'd1 << 14)) >> 15);
            s = sine_abs(angle + HALF_PI_Q30, neg);
            prod = (decay((longint'(k) << 32) / ENTRIES) * s) >> 30;
            if (prod > ONE_Q30)
                prod = ONE_Q30;
            v = neg ? ONE_Q30 - prod : ONE_Q30 + prod;
            damped_table[k] = 17'((v + (64'd1 << 14)) >> 15);
        end
    endtask

    function automatic logic [15:0] fit_ratio(input longint unsigned r);
        longint unsigned span;
        if (cfg_max < cfg_min)
            return cfg_min;
        if (r > 65536)
            r = 65536;
        span = cfg_max - cfg_min;
        return 16'(cfg_min + ((span * r + 32768) >> 16));
    endfunction

    function automatic logic [15:0] waveform_value(input logic [2:0] m, input logic [31:0] t,
                                                   input logic [15:0] idx);
        longint unsigned period;
        longint unsigned pt;
        longint unsigned phase;
        longint unsigned count;
        longint unsigned offset;
        longint unsigned total;
        longint unsigned tri_r;
        longint unsigned width;
        period = cfg_period < 2 ? 2 : cfg_period;
        pt = t % period;
        phase = (pt << 16) / period;
        count = cfg_count > MAX_REGISTERS ? MAX_REGISTERS : cfg_count;
        case (m)
            MODE_SINE:
            begin
                offset = 0;
                if (count > 1)
                    offset = (longint'(idx) * 12 * 65536) / (100 * count);
                total = (phase + offset) & 65535;
                return fit_ratio(sine_table[(total * ENTRIES) >> 16]);
            end
            MODE_SQUARE:
                return phase < 32768 ? cfg_min : cfg_max;
            MODE_TRIANGLE:
            begin
                tri_r = phase < 32768 ? 2 * phase : 2 * (65536 - phase);
                return fit_ratio(tri_r);
            end
            MODE_COUNTER:
            begin
                if (cfg_max < cfg_min)
                    return cfg_min;
                return 16'(cfg_min + (((longint'(t) + idx) * cfg_step)
                                      % (longint'(cfg_max - cfg_min) + 1)));
            end
            MODE_SAWTOOTH:
                return fit_ratio(phase);
            MODE_PULSE:
            begin
                width = period / 10;
                if (width < 1)
                    width = 1;
                return pt < width ? cfg_max : cfg_min;
            end
            MODE_DAMPED:
                return fit_ratio(damped_table[(phase * ENTRIES) >> 16]);
            default:
                return cfg_min;
        endcase
    endfunction

    task automatic write_register(input logic [2:0] which, input logic [16:0] data);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= which;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (which)
            REG_MINIMUM: cfg_min = data[15:0];
            REG_MAXIMUM: cfg_max = data[15:0];
            REG_PERIOD:  cfg_period = data[15:0];
            REG_STEP:    cfg_step = data[15:0];
            REG_COUNT:   cfg_count = data;
            default: ;
        endcase
    endtask

    // Sends one request; the expected value is queued at the accepting edge.
    task automatic send_request(input logic [2:0] m, input logic [31:0] t, input logic [15:0] idx,
                                input bit known, input logic [15:0] fixed, input bit gaps);
        if (gaps)
        begin
            while ($urandom_range(99) < 8)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        mode <= m;
        tick <= t;
        index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_values.push_back(known ? fixed : waveform_value(m, t, idx));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_values.size() > 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // Results are sampled at the edge that ends their cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, value);
                errors++;
            end
            else
            begin
                if (value !== pending_values[0])
                begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, pending_values[0], value);
                    errors++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_vector(input logic [2:0] m, input logic [31:0] t, input logic [15:0] idx,
                              input bit known, input logic [15:0] fixed);
        vector_t v;
        v.mode = m;
        v.tick = t;
        v.index = idx;
        v.known = known;
        v.value = fixed;
        vectors.push_back(v);
    endtask

    task automatic random_phase(input int items, input bit gaps);
        logic [2:0]  m;
        logic [31:0] t;
        logic [15:0] idx;
        for (int i = 0; i < items; i++)
        begin
            m = 3'($urandom_range(7));
            case ($urandom_range(3))
                0: t = $urandom;
                1: t = $urandom_range(200);
                2: t = 32'hFFFF_FFFF - $urandom_range(50);
                default: t = $urandom_range(65535);
            endcase
            idx = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(15));
            send_request(m, t, idx, 1'b0, 16'h0, gaps);
        end
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        tick = '0;
        index = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        cfg_min = 16'd0;
        cfg_max = 16'd65535;
        cfg_period = 16'd20;
        cfg_step = 16'd1;
        cfg_count = 17'd1;
        fill_tables();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset defaults (period 20, full range).
        add_vector(MODE_SQUARE, 32'd0, 16'd0, 1'b1, 16'd0);
        add_vector(MODE_SQUARE, 32'd10, 16'd0, 1'b1, 16'hFFFF);
        add_vector(MODE_PULSE, 32'd2, 16'd0, 1'b1, 16'd0);
        add_vector(MODE_PULSE, 32'd0, 16'd0, 1'b1, 16'hFFFF);
        add_vector(MODE_SAWTOOTH, 32'd0, 16'd0, 1'b1, 16'd0);
        add_vector(MODE_TRIANGLE, 32'd10, 16'd0, 1'b1, 16'hFFFF);
        add_vector(MODE_COUNTER, 32'd5, 16'd7, 1'b1, 16'd12);
        add_vector(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'd0);
        add_vector(MODE_SINE, 32'd0, 16'hFFFF, 1'b0, 16'd0);
        add_vector(MODE_SINE, 32'd5, 16'd0, 1'b0, 16'd0);
        add_vector(MODE_DAMPED, 32'd0, 16'd0, 1'b0, 16'd0);
        add_vector(MODE_DAMPED, 32'd13, 16'd0, 1'b0, 16'd0);
        add_vector(MODE_TRIANGLE, 32'd3, 16'd0, 1'b0, 16'd0);
        add_vector(MODE_COUNTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'd0);
        foreach (vectors[i])
            send_request(vectors[i].mode, vectors[i].tick, vectors[i].index,
                         vectors[i].known, vectors[i].value, 1'b1);
        drain();

        // Extremes: period below two, large count, inverted range.
        write_register(REG_PERIOD, 17'd1);
        write_register(REG_COUNT, 17'h1FFFF);
        write_register(REG_MINIMUM, 17'd40000);
        write_register(REG_MAXIMUM, 17'd100);
        write_register(REG_STEP, 17'hFFFF);
        send_request(MODE_COUNTER, 32'd9, 16'd3, 1'b1, 16'd40000, 1'b0);
        send_request(MODE_SAWTOOTH, 32'd1, 16'd3, 1'b1, 16'd40000, 1'b0);
        send_request(MODE_SQUARE, 32'd1, 16'd0, 1'b1, 16'd100, 1'b0);
        send_request(MODE_SINE, 32'd1, 16'hFFFF, 1'b1, 16'd40000, 1'b0);
        random_phase(150, 1'b1);
        drain();

        write_register(REG_MINIMUM, 17'd0);
        write_register(REG_MAXIMUM, 17'hFFFF);
        write_register(REG_PERIOD, 17'hFFFF);
        write_register(REG_COUNT, 17'd0);
        random_phase(250, 1'b1);
        drain();

        write_register(REG_MINIMUM, 17'd1000);
        write_register(REG_MAXIMUM, 17'd1000);
        write_register(REG_PERIOD, 17'd2);
        write_register(REG_STEP, 17'd1);
        write_register(REG_COUNT, 17'd2);
        random_phase(200, 1'b1);
        drain();

        // Long stretch without gaps.
        write_register(REG_MINIMUM, 17'd123);
        write_register(REG_MAXIMUM, 17'd50000);
        write_register(REG_PERIOD, 17'd37);
        write_register(REG_STEP, 17'd777);
        write_register(REG_COUNT, 17'd10);
        random_phase(400, 1'b0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_register(REG_MINIMUM, 17'($urandom_range(30000)));
            write_register(REG_MAXIMUM, 17'($urandom_range(65535, 20000)));
            write_register(REG_PERIOD, 17'($urandom_range(p % 2 ? 65535 : 200, 2)));
            write_register(REG_STEP, 17'($urandom_range(65535, 1)));
            write_register(REG_COUNT, 17'($urandom_range(p == 5 ? 65536 : 300, 1)));
            random_phase(150, 1'b1);
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### register_waveform_generator_unit.f
design/rwg_pkg.sv
design/rwg_divider.sv
design/rwg_rom.sv
design/register_waveform_generator_unit.sv
tb/tb_register_waveform_generator_unit.sv
